// ----- rtl/cma_pkg.sv -----
// Types and constants shared by the centered moving average block.
// No dependencies.
package cma_pkg;

    localparam int SMP_W  = 16;
    localparam int SUM_W  = 21;
    localparam int HIST_D = 32;
    localparam int ADDR_W = 5;
    localparam int CNT_W  = 6;
    localparam int LAG_W  = 5;
    localparam int HW_W   = 4;
    localparam int DIV_W  = 5;
    localparam int WIN_W  = 5;

    localparam logic [WIN_W-1:0] WINDOW_RST   = WIN_W'(5);
    localparam logic [SMP_W-1:0] ENDPOINT_RST = SMP_W'(1638);
    localparam logic [CNT_W-1:0] SEEN_TOP     = CNT_W'(63);
    localparam logic [CNT_W-1:0] SEEN_WRAP    = CNT_W'(32);

    typedef enum logic {
        CFG_WINDOW   = 1'b0,
        CFG_ENDPOINT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_SUM,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/cma_if.sv -----
// Valid/ready channels for sample requests and filtered results.
// Depends on cma_pkg.
interface cma_in_if;
    logic                      valid;
    logic                      ready;
    logic [cma_pkg::SMP_W-1:0] sample;
    logic                      block_end;
    modport source (output valid, sample, block_end, input ready);
    modport sink (input valid, sample, block_end, output ready);
endinterface

interface cma_out_if;
    logic                      valid;
    logic                      ready;
    logic [cma_pkg::SMP_W-1:0] filtered;
    logic                      final_output;
    modport source (output valid, filtered, final_output, input ready);
    modport sink (input valid, filtered, final_output, output ready);
endinterface

// ----- rtl/cma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/cma_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module cma_div #(
    parameter int N = 21,
    parameter int M = 5
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [M-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quotient
);
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  r_dvd;
    logic [M-1:0]  r_rem;
    logic [M-1:0]  r_dsr;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [M:0]    rem_sh;
    logic          take;

    assign rem_sh = {r_rem, r_dvd[N-1]};
    assign take   = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N);
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[N-2:0], take};
                r_rem <= take ? M'(rem_sh - {1'b0, r_dsr}) : rem_sh[M-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;
endmodule

// ----- rtl/centered_moving_average.sv -----
// Centered moving average over blocks of unsigned samples; history in cma_ram.
// Depends on cma_pkg, cma_if, cma_ram, cma_div.
// An averaged result passes the plan state, the sum state (2h+1 reads, read latency,
// divider start), the divider and an output load; an endpoint skips sum and divider.
// A no-result sample goes back to idle from plan; a flush sample yields up to hw+1 results.
// Synchronous reset clears state, seen count, lag, output valid and config registers.
module centered_moving_average #(
    parameter int MAX_HALF = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    cma_in_if.sink                    i_smp,
    cma_out_if.source                 o_res,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [cma_pkg::SMP_W-1:0] i_cfg_data
);
    import cma_pkg::*;

    localparam int               CAP  = (MAX_HALF < 15) ? MAX_HALF : 15;
    localparam logic [HW_W-1:0]  HCAP = HW_W'(CAP);

    t_state r_state, n_state;

    logic [WIN_W-1:0]  r_window;
    logic [SMP_W-1:0]  r_endpoint;
    logic [CNT_W-1:0]  r_seen, n_seen;
    logic [LAG_W-1:0]  r_lag, n_lag;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_s, n_s;
    logic              r_flush, n_flush;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [DIV_W-1:0]  r_left, n_left;
    logic [DIV_W-1:0]  r_dsr, n_dsr;
    logic              r_pend, n_pend;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_use_ep, n_use_ep;
    logic              r_out_vld, n_out_vld;
    logic [SMP_W-1:0]  r_out_val, n_out_val;
    logic              r_out_fin, n_out_fin;

    logic [HW_W-1:0]   hw;
    logic [HW_W-1:0]   h;
    logic [CNT_W-1:0]  h_ext;
    logic [CNT_W-1:0]  tail;
    logic              acc;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_q;
    logic [SMP_W-1:0]  rdata;

    assign hw = (r_window[WIN_W-1:1] > HCAP) ? HCAP : r_window[WIN_W-1:1];

    always_comb begin
        tail  = r_s - r_i;
        h_ext = {{(CNT_W-HW_W){1'b0}}, hw};
        if (r_i < h_ext) begin
            h_ext = r_i;
        end
        if (r_flush && tail < h_ext) begin
            h_ext = tail;
        end
        h = h_ext[HW_W-1:0];
    end

    assign acc      = i_smp.valid && i_smp.ready;
    assign out_free = !r_out_vld || o_res.ready;

    cma_ram #(
        .WIDTH(SMP_W),
        .DEPTH(HIST_D)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (acc),
        .i_waddr(r_seen[ADDR_W-1:0]),
        .i_wdata(i_smp.sample),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    cma_div #(
        .N(SUM_W),
        .M(DIV_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_sum),
        .i_divisor (r_dsr),
        .o_done    (div_done),
        .o_quotient(div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_endpoint <= ENDPOINT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW:   r_window <= i_cfg_data[WIN_W-1:0];
                CFG_ENDPOINT: r_endpoint <= i_cfg_data;
                default:      r_window <= r_window;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seen    <= '0;
            r_lag     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_seen    <= n_seen;
            r_lag     <= n_lag;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
        r_i       <= n_i;
        r_s       <= n_s;
        r_flush   <= n_flush;
        r_addr    <= n_addr;
        r_left    <= n_left;
        r_dsr     <= n_dsr;
        r_sum     <= n_sum;
        r_use_ep  <= n_use_ep;
        r_out_val <= n_out_val;
        r_out_fin <= n_out_fin;
    end

    always_comb begin
        n_state   = r_state;
        n_seen    = r_seen;
        n_lag     = r_lag;
        n_i       = r_i;
        n_s       = r_s;
        n_flush   = r_flush;
        n_addr    = r_addr;
        n_left    = r_left;
        n_dsr     = r_dsr;
        n_pend    = 1'b0;
        n_sum     = r_sum;
        n_use_ep  = r_use_ep;
        n_out_vld = r_out_vld && !o_res.ready;
        n_out_val = r_out_val;
        n_out_fin = r_out_fin;
        div_start = 1'b0;
        i_smp.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_smp.ready = 1'b1;
                if (acc) begin
                    n_s     = r_seen;
                    n_i     = r_seen - CNT_W'(r_lag);
                    n_flush = i_smp.block_end;
                    if (i_smp.block_end) begin
                        n_seen = '0;
                        n_lag  = '0;
                    end else begin
                        n_seen = (r_seen >= SEEN_TOP) ? SEEN_WRAP : r_seen + 1'b1;
                    end
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                if (!r_flush && (7'(r_i) + 7'(h) > 7'(r_s))) begin
                    n_lag   = r_lag + 1'b1;
                    n_state = S_IDLE;
                end else if (r_i == '0 || (r_flush && r_i == r_s)) begin
                    n_use_ep = 1'b1;
                    n_state  = S_EMIT;
                end else begin
                    n_use_ep = 1'b0;
                    n_addr   = r_i[ADDR_W-1:0] - ADDR_W'(h);
                    n_left   = {h, 1'b1};
                    n_dsr    = {h, 1'b1};
                    n_sum    = '0;
                    n_state  = S_SUM;
                end
            end
            S_SUM: begin
                if (r_pend) begin
                    n_sum = r_sum + SUM_W'(rdata);
                end
                if (r_left != '0) begin
                    n_addr = r_addr + 1'b1;
                    n_left = r_left - 1'b1;
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out_val = r_use_ep ? r_endpoint : div_q[SMP_W-1:0];
                    n_out_fin = r_flush && (r_i == r_s);
                    if (r_flush && r_i != r_s) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_PLAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.filtered     = r_out_val;
    assign o_res.final_output = r_out_fin;

`ifndef SYNTHESIS
    a_lag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_lag <= LAG_W'(CAP))
        else $error("output lag exceeds half width");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide phase");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |=> (r_out_vld && $stable(r_out_val)))
        else $error("pending result overwritten");
    a_sum_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dsr[0])
        else $error("divisor not odd");
`endif
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for centered_moving_average: sends sample blocks and
// checks every result against an in-bench average predictor. Depends on cma_pkg,
// cma_if and the block's RTL.
module tb_top;
    import cma_pkg::*;

    typedef struct packed {
        logic [SMP_W-1:0] filtered;
        logic             final_output;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [SMP_W-1:0] i_cfg_data;

    cma_in_if  smp();
    cma_out_if res();

    centered_moving_average DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_result          avg_expected[$];
    logic [SMP_W-1:0] hist[HIST_D];
    int               seen;
    int               lag;
    logic [WIN_W-1:0] win_cfg;
    logic [SMP_W-1:0] endpoint_cfg;
    int               errors;
    int               sent;
    bit               idle_on;
    bit               hold_req;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int half_w();
        int w;
        int h;
        w = win_cfg;
        if (w % 2 == 0) w++;
        h = (w - 1) / 2;
        return (h > 15) ? 15 : h;
    endfunction

    function automatic logic [SMP_W-1:0] span_mean(input int i, input int h);
        logic [31:0] sum;
        sum = 0;
        for (int j = i - h; j <= i + h; j++) sum += hist[ADDR_W'(j)];
        return SMP_W'(sum / (2 * h + 1));
    endfunction

    task automatic predict_average(input logic [SMP_W-1:0] s, input logic last);
        int hw;
        int o;
        int h;
        t_result r;
        hw = half_w();
        o = seen - lag;
        hist[ADDR_W'(seen)] = s;
        if (last) begin
            for (int i = o; i <= seen; i++) begin
                h = hw;
                if (i < h) h = i;
                if (seen - i < h) h = seen - i;
                r.filtered = (i == 0 || i == seen) ? endpoint_cfg : span_mean(i, h);
                r.final_output = (i == seen);
                avg_expected.push_back(r);
            end
            seen = 0;
            lag = 0;
        end else begin
            h = (o < hw) ? o : hw;
            if (o + h <= seen) begin
                r.filtered = (o == 0) ? endpoint_cfg : span_mean(o, h);
                r.final_output = 1'b0;
                avg_expected.push_back(r);
            end else begin
                lag = (lag + 1) % 32;
            end
            seen = (seen >= 63) ? 32 : seen + 1;
        end
    endtask

    task automatic send_sample(input logic [SMP_W-1:0] s, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        smp.valid     <= 1'b1;
        smp.sample    <= s;
        smp.block_end <= last;
        do @(posedge i_clk); while (!smp.ready);
        predict_average(s, last);
        sent++;
    endtask

    task automatic send_block(input int len, input bit extremes);
        logic [SMP_W-1:0] s;
        for (int k = 0; k < len; k++) begin
            s = SMP_W'($urandom_range(0, 65535));
            if (extremes && $urandom_range(0, 2) == 0) s = $urandom_range(0, 1) ? '1 : '0;
            send_sample(s, k == len - 1);
        end
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (avg_expected.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [WIN_W-1:0] w, input logic [SMP_W-1:0] ep);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WINDOW;
        i_cfg_data <= SMP_W'(w);
        @(posedge i_clk);
        win_cfg = w;
        i_cfg_idx  <= CFG_ENDPOINT;
        i_cfg_data <= ep;
        @(posedge i_clk);
        endpoint_cfg = ep;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_edges();
        send_sample('0, 1'b1);
        send_sample('1, 1'b1);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample('1, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b1);
    endtask

    task automatic test_window_zero();
        set_config(5'd0, '0);
        send_block(4, 1'b1);
    endtask

    task automatic test_short_wide();
        set_config(5'd31, '1);
        send_block(2, 1'b1);
        send_block(3, 1'b1);
        send_block(5, 1'b0);
    endtask

    task automatic test_even_window();
        set_config(5'd2, 16'h5a5a);
        send_block(6, 1'b0);
    endtask

    task automatic test_backpressure();
        set_config(5'd9, 16'h1234);
        hold_req = 1'b1;
        send_block(40, 1'b0);
    endtask

    task automatic test_drain_pause();
        send_block(12, 1'b0);
        smp.valid <= 1'b0;
        while (avg_expected.size() != 0) @(posedge i_clk);
        send_block(8, 1'b1);
    endtask

    task automatic test_random();
        int len;
        while (sent < 420) begin
            if ($urandom_range(0, 4) == 0)
                set_config(WIN_W'($urandom_range(0, 31)), SMP_W'($urandom_range(0, 65535)));
            if (sent > 350) idle_on = 1'b0;
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 20);
            if (len > 420 - sent) len = 420 - sent;
            send_block(len, 1'($urandom_range(0, 1)));
        end
    endtask

    // drive result ready: random stall bursts, one long hold on request
    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res.ready <= 1'b0;
                repeat (500) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (avg_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", res.filtered));
            end else begin
                if (res.filtered !== avg_expected[0].filtered)
                    report_mismatch($sformatf("filtered %0d, want %0d",
                                              res.filtered, avg_expected[0].filtered));
                if (res.final_output !== avg_expected[0].final_output)
                    report_mismatch($sformatf("final_output %0b, want %0b",
                                              res.final_output, avg_expected[0].final_output));
                void'(avg_expected.pop_front());
            end
        end
    end

    initial begin
        #30ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WINDOW;
        i_cfg_data    <= '0;
        smp.valid     <= 1'b0;
        smp.sample    <= '0;
        smp.block_end <= 1'b0;
        errors   = 0;
        sent     = 0;
        seen     = 0;
        lag      = 0;
        win_cfg  = WINDOW_RST;
        endpoint_cfg = ENDPOINT_RST;
        idle_on  = 1'b1;
        hold_req = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        test_window_zero();
        test_short_wide();
        test_even_window();
        test_backpressure();
        test_drain_pause();
        test_random();
        wait_drained();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
